>>> sv/ecal_pkg.sv
`default_nettype none

package ecal_pkg;

  // datapath widths
  localparam int XW  = 26;          // divider operand
  localparam int MW  = 27;          // reciprocal constant
  localparam int PW  = XW + MW;     // reciprocal product
  localparam int QW  = 17;          // quotient
  localparam int RW  = 12;          // remainder, divisors
  localparam int QDW = QW + RW;     // quotient times divisor

  // divider passes, also the divisor select
  localparam logic [1:0] PASS_DAY  = 2'd0;
  localparam logic [1:0] PASS_HOUR = 2'd1;
  localparam logic [1:0] PASS_MIN  = 2'd2;
  localparam logic [1:0] PASS_YEAR = 2'd3;

  // reciprocal shift per pass
  localparam int SH_DAY  = 36;
  localparam int SH_HOUR = 29;
  localparam int SH_MIN  = 18;
  localparam int SH_YEAR = 26;

  // floor(2^shift / divisor); the estimate is low by at most one
  localparam logic [MW-1:0] RECIP [4] = '{
    27'd101806632, 27'd149130, 27'd4369, 27'd45933
  };
  localparam logic [RW-1:0] DIVISOR [4] = '{
    12'd675, 12'd3600, 12'd60, 12'd1461
  };

  // input offset: makes the count non-negative and aligned to whole days
  localparam logic [32:0] SEC_BIAS  = 33'd74752;
  // days from 1901-01-01 to the first biased day
  localparam logic [15:0] DAYS_BIAS = 16'd346;
  localparam logic [10:0] BASE_YEAR = 11'd1901;

  // microcode operations
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_QD    = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_NEXT  = 3'd3;
  localparam logic [2:0] OP_YEAR  = 3'd4;
  localparam logic [2:0] OP_MONTH = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       loop;     // jump to target while passes remain
    logic [2:0] target;
  } uword_t;

  localparam int USTEPS = 6;
  localparam int SW     = 3;

  localparam uword_t UCODE [USTEPS] = '{
    '{OP_MUL,   1'b0, 3'd0},
    '{OP_QD,    1'b0, 3'd0},
    '{OP_SUB,   1'b0, 3'd0},
    '{OP_NEXT,  1'b1, 3'd0},
    '{OP_YEAR,  1'b0, 3'd0},
    '{OP_MONTH, 1'b0, 3'd0}
  };

  // controls from the sequencer to the divider
  typedef struct packed {
    logic       mul_en;
    logic       qd_en;
    logic       sub_en;
    logic [1:0] sel;
  } div_ctl_t;

  // first day of each month, common and leap years
  localparam logic [8:0] CUM [2][12] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
  };

endpackage

`default_nettype wire

>>> sv/ecal_cdiv.sv
`default_nettype none

module ecal_cdiv (
  input  wire logic                    clk,
  input  wire logic [ecal_pkg::XW-1:0] x,
  input  var  ecal_pkg::div_ctl_t      ctl,
  output logic [ecal_pkg::QW-1:0]      q,
  output logic [ecal_pkg::RW-1:0]      r
);

  logic [ecal_pkg::PW-1:0]  prod;
  logic [ecal_pkg::QW-1:0]  q_est;
  logic [ecal_pkg::QW-1:0]  q_raw;
  logic [ecal_pkg::XW-1:0]  qd;
  logic [ecal_pkg::XW-1:0]  diff;
  logic [ecal_pkg::RW:0]    r_raw;
  logic [ecal_pkg::RW-1:0]  dsr;

  assign dsr = ecal_pkg::DIVISOR[ctl.sel];

  // quotient estimate from the reciprocal product
  always_comb begin
    case (ctl.sel)
      ecal_pkg::PASS_DAY:  q_est = prod[ecal_pkg::SH_DAY  +: ecal_pkg::QW];
      ecal_pkg::PASS_HOUR: q_est = prod[ecal_pkg::SH_HOUR +: ecal_pkg::QW];
      ecal_pkg::PASS_MIN:  q_est = prod[ecal_pkg::SH_MIN  +: ecal_pkg::QW];
      default:             q_est = prod[ecal_pkg::SH_YEAR +: ecal_pkg::QW];
    endcase
  end

  // remainder before the single correction, below twice the divisor
  assign diff  = x - qd;
  assign r_raw = diff[ecal_pkg::RW:0];

  // multiply, back-multiply, subtract and correct
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= {{ecal_pkg::MW{1'b0}}, x} * {{ecal_pkg::XW{1'b0}}, ecal_pkg::RECIP[ctl.sel]};
    end
    if (ctl.qd_en) begin
      q_raw <= q_est;
      qd    <= ecal_pkg::XW'({{ecal_pkg::RW{1'b0}}, q_est} * {{ecal_pkg::QW{1'b0}}, dsr});
    end
    if (ctl.sub_en) begin
      if (r_raw >= {1'b0, dsr}) begin
        r <= ecal_pkg::RW'(r_raw - {1'b0, dsr});
        q <= q_raw + ecal_pkg::QW'(1);
      end else begin
        r <= r_raw[ecal_pkg::RW-1:0];
        q <= q_raw;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/epoch_seconds_to_calendar.sv
// channel   signals                                   handshake
// command   start, seconds_since_epoch, busy           beat taken when start & !busy
// result    done, year, month, day, hour, minute,      beat shown for one cycle on done,
//           second                                     never held off
//
// one item takes 19 cycles from the accepting edge to the done cycle, and a new
// beat may be taken in the done cycle itself, so one item per 19 cycles
// the figure is set by four constant divisions (675, 3600, 60, 1461) run through
// one shared reciprocal multiplier, four microcode steps each, plus two steps
// for the year and month
// rst (synchronous) idles the sequencer and drops busy and done
// results are valid only in the done cycle; the receiver cannot stall

`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] seconds_since_epoch,
  output logic             busy,
  output logic             done,
  output logic [10:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  logic                       running;
  logic [ecal_pkg::SW-1:0]    step;
  logic [1:0]                 pass;
  logic [ecal_pkg::XW-1:0]    x;
  logic [6:0]                 lo7;
  logic [15:0]                days_ofs;
  logic [5:0]                 cyc;
  logic [10:0]                r_cyc;
  logic [8:0]                 doy;
  logic                       leap;

  ecal_pkg::uword_t           cw;
  ecal_pkg::div_ctl_t         dctl;
  logic [ecal_pkg::QW-1:0]    q;
  logic [ecal_pkg::RW-1:0]    r;
  logic [32:0]                biased;
  logic [1:0]                 yi;
  logic [10:0]                yi_days;
  logic [3:0]                 mi;
  logic                       accept;

  assign busy   = running;
  assign accept = start && !running;
  assign cw     = ecal_pkg::UCODE[step];
  assign biased = {1'b0, ~seconds_since_epoch[31], seconds_since_epoch[30:0]}
                  + ecal_pkg::SEC_BIAS;

  // divider controls from the current control word
  always_comb begin
    dctl.mul_en = running && (cw.op == ecal_pkg::OP_MUL);
    dctl.qd_en  = running && (cw.op == ecal_pkg::OP_QD);
    dctl.sub_en = running && (cw.op == ecal_pkg::OP_SUB);
    dctl.sel    = pass;
  end

  ecal_cdiv u_cdiv (
    .clk (clk),
    .x   (x),
    .ctl (dctl),
    .q   (q),
    .r   (r)
  );

  // year within the four-year cycle, the last year of each cycle is leap
  always_comb begin
    if (r_cyc >= 11'd1095) begin
      yi = 2'd3;
      yi_days = 11'd1095;
    end else if (r_cyc >= 11'd730) begin
      yi = 2'd2;
      yi_days = 11'd730;
    end else if (r_cyc >= 11'd365) begin
      yi = 2'd1;
      yi_days = 11'd365;
    end else begin
      yi = 2'd0;
      yi_days = 11'd0;
    end
  end

  // month: last table entry not past the day of year
  always_comb begin
    mi = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= ecal_pkg::CUM[leap][k]) begin
        mi = 4'(k);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      pass    <= ecal_pkg::PASS_DAY;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        running <= 1'b1;
        step    <= '0;
        pass    <= ecal_pkg::PASS_DAY;
      end else if (running) begin
        if (cw.op == ecal_pkg::OP_MONTH) begin
          running <= 1'b0;
          step    <= '0;
          done    <= 1'b1;
        end else if (cw.loop && (pass != ecal_pkg::PASS_YEAR)) begin
          step <= cw.target;
        end else begin
          step <= step + ecal_pkg::SW'(1);
        end
        if (cw.op == ecal_pkg::OP_NEXT) begin
          pass <= pass + 2'd1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= biased[32:7];
      lo7 <= biased[6:0];
    end else if (running) begin
      unique case (cw.op) inside
        ecal_pkg::OP_NEXT: begin
          unique case (pass)
            ecal_pkg::PASS_DAY: begin
              days_ofs <= q[15:0];
              x        <= ecal_pkg::XW'({r[9:0], lo7});
            end
            ecal_pkg::PASS_HOUR: begin
              hour <= q[4:0];
              x    <= ecal_pkg::XW'(r);
            end
            ecal_pkg::PASS_MIN: begin
              minute <= q[5:0];
              second <= r[5:0];
              x      <= ecal_pkg::XW'(days_ofs + ecal_pkg::DAYS_BIAS);
            end
            ecal_pkg::PASS_YEAR: begin
              cyc   <= q[5:0];
              r_cyc <= r[10:0];
            end
          endcase
        end
        ecal_pkg::OP_YEAR: begin
          year <= ecal_pkg::BASE_YEAR + 11'({cyc, 2'b00}) + 11'(yi);
          doy  <= 9'(r_cyc - yi_days);
          leap <= (yi == 2'd3);
        end
        ecal_pkg::OP_MONTH: begin
          month <= mi + 4'd1;
          day   <= 5'(doy - ecal_pkg::CUM[leap][mi] + 9'd1);
        end
        ecal_pkg::OP_MUL, ecal_pkg::OP_QD, ecal_pkg::OP_SUB: begin
        end
        default: begin
        end
      endcase
    end
  end

  // the month step always ends in a result beat
  a_month_done: assert property (@(posedge clk) disable iff (rst)
    (running && (cw.op == ecal_pkg::OP_MONTH)) |=> done)
    else $error("month step without result beat");

  // an accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted beat did not start the sequencer");

  // month, hour, minute and second in range and day at least one on every result beat
  a_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
              hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("result field out of range");

  // one result beat per item
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

endmodule

`default_nettype wire
